// ===== rtl/vnt_pkg.sv =====
package vnt_pkg;

    localparam int DEF_COORD_BITS = 24;
    localparam int DEF_FRAC_BITS  = 16;

    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int HEIGHT_BITS    = 19;
    localparam int LIMIT_BITS     = 19;
    localparam int SCALE_BITS     = 24;
    localparam int WIDE_BITS      = 43;

    // lattice hash
    localparam logic [31:0] HASH_X   = 32'd1327;
    localparam logic [31:0] HASH_Y   = 32'd9743;
    localparam logic [31:0] HASH_MUL = 32'h045d9f3b;

    // floor(w / 125) = (w * DIV125_MUL) >> DIV125_SHIFT for w below 2^31
    localparam logic [31:0] DIV125_MUL   = 32'd2199023256;
    localparam int          DIV125_SHIFT = 38;

    // floor(s / 7) = (s * DIV7_MUL) >> DIV7_SHIFT for s below 2^27
    localparam logic [27:0] DIV7_MUL   = 28'd153391690;
    localparam int          DIV7_SHIFT = 30;

    localparam logic [31:0]           RST_SEED      = 32'd0;
    localparam logic [SCALE_BITS-1:0] RST_INV_SCALE = 24'd524288;
    localparam logic [31:0]           RST_INV_AREA  = 32'd429497;
    localparam logic [LIMIT_BITS-1:0] RST_WATER     = 19'd19661;
    localparam logic [LIMIT_BITS-1:0] RST_DIRT      = 19'd26214;
    localparam logic [LIMIT_BITS-1:0] RST_GRASS     = 19'd45875;

    typedef enum logic [1:0] {
        MODE_ISLAND,
        MODE_ARCHIPELAGO,
        MODE_CONTINENTS,
        MODE_PANGEA
    } t_map_mode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SEED,
        CFG_MODE,
        CFG_INV_SCALE,
        CFG_INV_AREA,
        CFG_WATER,
        CFG_DIRT,
        CFG_GRASS
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CLS_WATER,
        CLS_DIRT,
        CLS_GRASS,
        CLS_MOUNTAIN
    } t_class;

endpackage

// ===== rtl/vnt_ifs.sv =====
interface vnt_in_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] tile_q;
    logic signed [COORD_BITS-1:0] tile_r;

    modport source (output valid, output tile_q, output tile_r, input ready);
    modport sink   (input valid, input tile_q, input tile_r, output ready);
endinterface

interface vnt_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         terrain_class;
    logic signed [18:0] terrain_height;

    modport source (output valid, output terrain_class, output terrain_height, input ready);
    modport sink   (input valid, input terrain_class, input terrain_height, output ready);
endinterface

// ===== rtl/value_noise_terrain_classifier_top.sv =====
// Terrain classifier: one tile coordinate in, one terrain class and height out.
//
// i_tile carries tile_q / tile_r; a word is taken when valid and ready are high.
// o_terrain carries terrain_class and terrain_height (signed, FRAC_BITS fraction
// bits, saturated to 19 bits). The configuration port writes one register per
// cycle with i_cfg_we; write it only while no tile is in flight.
//
// The datapath is an 11-stage pipeline: hash lattice corners (four stages per
// hash), blend, octave sum, map-mode shaping, classify. A new tile is taken every
// cycle while the output is not stalled. The continent noise lane runs behind
// the main octaves because its lattice index comes from a divide by 500 done
// as a reciprocal multiply.
//
// Reset clears the configuration registers to their defaults and drops every
// word in flight. When the receiver holds ready low with a result waiting, the
// whole pipeline freezes and i_tile.ready drops; nothing is lost or repeated.
module value_noise_terrain_classifier_top import vnt_pkg::*; #(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    vnt_in_if.sink                   i_tile,
    vnt_out_if.source                o_terrain,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int CB   = COORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int XW   = CB + 27;
    localparam int HW   = WIDE_BITS;
    localparam int LAST = 11;
    localparam int ONE  = 1 << F;
    localparam int C_TENTH     = (ONE + 5) / 10;
    localparam int C_FIFTH     = (2 * ONE + 5) / 10;
    localparam int C_TWOFIFTHS = (4 * ONE + 5) / 10;
    localparam logic [56:0]          TERM_CAP = 57'(1) << 40;
    localparam logic signed [HW-1:0] H_MAX = HW'((2 ** (HEIGHT_BITS - 1)) - 1);
    localparam logic signed [HW-1:0] H_MIN = HW'(-(2 ** (HEIGHT_BITS - 1)));

    function automatic logic [F-1:0] f_blend(input logic [F-1:0] a,
                                             input logic [F-1:0] b,
                                             input logic [F-1:0] t);
        logic signed [F+1:0]   d;
        logic signed [2*F+2:0] p;
        d = $signed({2'b00, b}) - $signed({2'b00, a});
        p = d * $signed({1'b0, t});
        return F'(p >>> F) + a;
    endfunction

    // configuration registers
    logic [31:0]                   r_seed;
    t_map_mode                     r_mode;
    logic [SCALE_BITS-1:0]         r_inv_scale;
    logic [31:0]                   r_inv_area;
    logic signed [LIMIT_BITS-1:0]  r_water;
    logic signed [LIMIT_BITS-1:0]  r_dirt;
    logic signed [LIMIT_BITS-1:0]  r_grass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= RST_SEED;
            r_mode      <= MODE_ISLAND;
            r_inv_scale <= RST_INV_SCALE;
            r_inv_area  <= RST_INV_AREA;
            r_water     <= RST_WATER;
            r_dirt      <= RST_DIRT;
            r_grass     <= RST_GRASS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SEED:      r_seed      <= i_cfg_data;
                CFG_MODE:      r_mode      <= t_map_mode'(i_cfg_data[1:0]);
                CFG_INV_SCALE: r_inv_scale <= i_cfg_data[SCALE_BITS-1:0];
                CFG_INV_AREA:  r_inv_area  <= i_cfg_data;
                CFG_WATER:     r_water     <= i_cfg_data[LIMIT_BITS-1:0];
                CFG_DIRT:      r_dirt      <= i_cfg_data[LIMIT_BITS-1:0];
                CFG_GRASS:     r_grass     <= i_cfg_data[LIMIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control: freeze everything while the output word is stalled
    logic            w_en;
    logic [LAST:1]   r_vld;

    assign w_en         = !r_vld[LAST] || o_terrain.ready;
    assign i_tile.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAST-1:1], i_tile.valid};
        end
    end

    // stage 1: scale, squares, reciprocal multiply for the divide by 500
    logic signed [CB+24:0] r_s1_xq, r_s1_xr;
    logic [2*CB-1:0]       r_s1_qq, r_s1_rr;
    logic [CB+31:0]        r_s1_pq, r_s1_pr;
    logic [CB-1:0]         r_s1_vq, r_s1_vr;
    logic                  r_s1_sq, r_s1_sr;
    logic signed [2*CB-1:0] n_qq, n_rr;
    logic [CB-1:0]         n_vq, n_vr;

    always_comb begin
        n_qq = i_tile.tile_q * i_tile.tile_q;
        n_rr = i_tile.tile_r * i_tile.tile_r;
        // floor division of a negative value works on its complement
        n_vq = i_tile.tile_q[CB-1] ? ~i_tile.tile_q : i_tile.tile_q;
        n_vr = i_tile.tile_r[CB-1] ? ~i_tile.tile_r : i_tile.tile_r;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_xq <= i_tile.tile_q * $signed({1'b0, r_inv_scale});
            r_s1_xr <= i_tile.tile_r * $signed({1'b0, r_inv_scale});
            r_s1_qq <= n_qq;
            r_s1_rr <= n_rr;
            r_s1_pq <= (n_vq >> 2) * DIV125_MUL;
            r_s1_pr <= (n_vr >> 2) * DIV125_MUL;
            r_s1_vq <= n_vq;
            r_s1_vr <= n_vr;
            r_s1_sq <= i_tile.tile_q[CB-1];
            r_s1_sr <= i_tile.tile_r[CB-1];
        end
    end

    // stage 2: lattice indices and fractions; quotient and remainder by 500
    logic [31:0]  w_ix [3];
    logic [31:0]  w_iy [3];
    logic [F-1:0] n_fx [3];
    logic [F-1:0] n_fy [3];
    logic [F-1:0] r_fx [2:5][3];
    logic [F-1:0] r_fy [2:6][3];

    always_comb begin
        logic signed [XW-1:0] xk;
        logic signed [XW-1:0] yk;
        for (int k = 0; k < 3; k++) begin
            xk      = XW'(r_s1_xq) <<< k;
            yk      = XW'(r_s1_xr) <<< k;
            w_ix[k] = 32'(xk >>> 24);
            w_iy[k] = 32'(yk >>> 24);
            n_fx[k] = xk[23 -: F];
            n_fy[k] = yk[23 -: F];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fx[2] <= n_fx;
            r_fy[2] <= n_fy;
            for (int s = 3; s <= 5; s++) r_fx[s] <= r_fx[s-1];
            for (int s = 3; s <= 6; s++) r_fy[s] <= r_fy[s-1];
        end
    end

    logic [CB-1:0]         w_aq, w_ar;
    logic [CB+8:0]         w_mq, w_mr;
    logic [8:0]            w_bq, w_br;
    logic signed [CB-1:0]  w_sq, w_sr;
    logic [31:0]           r_s2_caq, r_s2_car;
    logic [8:0]            r_s2_cbq, r_s2_cbr;
    logic [63:0]           r_s2_d2;

    always_comb begin
        w_aq = CB'(r_s1_pq >> DIV125_SHIFT);
        w_ar = CB'(r_s1_pr >> DIV125_SHIFT);
        w_mq = (CB+9)'(w_aq) * (CB+9)'(500);
        w_mr = (CB+9)'(w_ar) * (CB+9)'(500);
        w_bq = 9'((CB+9)'(r_s1_vq) - w_mq);
        w_br = 9'((CB+9)'(r_s1_vr) - w_mr);
        w_sq = r_s1_sq ? ~w_aq : w_aq;
        w_sr = r_s1_sr ? ~w_ar : w_ar;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_caq <= 32'(w_sq);
            r_s2_car <= 32'(w_sr);
            r_s2_cbq <= r_s1_sq ? 9'd499 - w_bq : w_bq;
            r_s2_cbr <= r_s1_sr ? 9'd499 - w_br : w_br;
            r_s2_d2  <= 64'(r_s1_qq) + 64'(r_s1_rr);
        end
    end

    // main octave corner hashes, values valid with stage 5
    logic [F-1:0] w_hv [3][4];

    for (genvar k = 0; k < 3; k++) begin : g_oct
        for (genvar c = 0; c < 4; c++) begin : g_corner
            vnt_hash #(.FRAC_BITS(F)) u_hash (
                .i_clk   (i_clk),
                .i_en    (w_en),
                .i_x     (w_ix[k] + 32'(c % 2)),
                .i_y     (w_iy[k] + 32'(c / 2)),
                .i_seed  (r_seed),
                .o_value (w_hv[k][c])
            );
        end
    end

    // continent corner hashes, values valid with stage 6
    logic [F-1:0] w_cv [4];

    for (genvar c = 0; c < 4; c++) begin : g_cont
        vnt_hash #(.FRAC_BITS(F)) u_hash (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_x     (r_s2_caq + 32'(c % 2)),
            .i_y     (r_s2_car + 32'(c / 2)),
            .i_seed  (r_seed + 32'd1),
            .o_value (w_cv[c])
        );
    end

    // stages 3-4: continent fraction, island distance term
    logic [F+38:0] r_s3_pfq, r_s3_pfr;
    logic [63:0]   r_s3_plo, r_s3_phi;
    logic [F-1:0]  r_cfx [4:6];
    logic [F-1:0]  r_cfy [4:7];
    logic [40:0]   r_term [4:9];
    logic [56:0]   w_tsum;
    logic          w_over;

    always_comb begin
        w_over = |(r_s3_phi >> (40 - F));
        w_tsum = 57'({r_s3_phi[39-F:0], {F{1'b0}}}) + 57'(r_s3_plo >> (32 - F));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_pfq <= ((F+7)'(r_s2_cbq) << (F - 2)) * DIV125_MUL;
            r_s3_pfr <= ((F+7)'(r_s2_cbr) << (F - 2)) * DIV125_MUL;
            r_s3_plo <= r_s2_d2[31:0] * r_inv_area;
            r_s3_phi <= r_s2_d2[63:32] * r_inv_area;
            r_cfx[4] <= F'(r_s3_pfq >> DIV125_SHIFT);
            r_cfy[4] <= F'(r_s3_pfr >> DIV125_SHIFT);
            for (int s = 5; s <= 6; s++) r_cfx[s] <= r_cfx[s-1];
            for (int s = 5; s <= 7; s++) r_cfy[s] <= r_cfy[s-1];
            // saturate the distance term at 2^40
            r_term[4] <= (w_over || (w_tsum > TERM_CAP)) ? 41'(TERM_CAP) : 41'(w_tsum);
            for (int s = 5; s <= 9; s++) r_term[s] <= r_term[s-1];
        end
    end

    // stages 6-9: bilinear blends, octave sum, divide by 7
    logic [F-1:0]   r_s6_top [3];
    logic [F-1:0]   r_s6_bot [3];
    logic [F-1:0]   r_s7_n [3];
    logic [F-1:0]   r_s7_ctop, r_s7_cbot;
    logic [F-1:0]   r_s8_c;
    logic [F+30:0]  r_s8_p7;
    logic [F-1:0]   r_s9_e;
    logic [F-1:0]   r_s9_ct;
    logic [F+2:0]   n_sum;
    logic [2*F-1:0] n_ct;

    always_comb begin
        n_sum = ((F+3)'(r_s7_n[0]) << 2) + ((F+3)'(r_s7_n[1]) << 1)
              + (F+3)'(r_s7_n[2]) + (F+3)'(3);
        n_ct  = r_s8_c * F'(C_TWOFIFTHS);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_s6_top[k] <= f_blend(w_hv[k][0], w_hv[k][1], r_fx[5][k]);
                r_s6_bot[k] <= f_blend(w_hv[k][2], w_hv[k][3], r_fx[5][k]);
                r_s7_n[k]   <= f_blend(r_s6_top[k], r_s6_bot[k], r_fy[6][k]);
            end
            r_s7_ctop <= f_blend(w_cv[0], w_cv[1], r_cfx[6]);
            r_s7_cbot <= f_blend(w_cv[2], w_cv[3], r_cfx[6]);
            r_s8_c    <= f_blend(r_s7_ctop, r_s7_cbot, r_cfy[7]);
            r_s8_p7   <= n_sum * DIV7_MUL;
            r_s9_e    <= F'(r_s8_p7 >> DIV7_SHIFT);
            r_s9_ct   <= F'(n_ct >> F);
        end
    end

    // stage 10: map-mode shaping; stage 11: classify and saturate
    logic signed [HW-1:0] w_e;
    logic signed [HW-1:0] n_h;
    logic signed [HW-1:0] r_s10_h;
    t_class               r_s11_cls;
    logic signed [HEIGHT_BITS-1:0] r_s11_h;

    always_comb begin
        w_e = HW'(r_s9_e);
        case (r_mode)
            MODE_ISLAND:      n_h = w_e + HW'(C_TENTH) - HW'(r_term[9]);
            MODE_ARCHIPELAGO: n_h = w_e - HW'(C_FIFTH);
            MODE_CONTINENTS:  n_h = w_e + HW'(r_s9_ct) - HW'(C_FIFTH);
            MODE_PANGEA:      n_h = w_e + HW'(C_FIFTH);
            default:          n_h = w_e;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s10_h <= n_h;
            if (r_s10_h < HW'(r_water)) begin
                r_s11_cls <= CLS_WATER;
            end else if (r_s10_h < HW'(r_dirt)) begin
                r_s11_cls <= CLS_DIRT;
            end else if (r_s10_h < HW'(r_grass)) begin
                r_s11_cls <= CLS_GRASS;
            end else begin
                r_s11_cls <= CLS_MOUNTAIN;
            end
            if (r_s10_h > H_MAX) begin
                r_s11_h <= HEIGHT_BITS'(H_MAX);
            end else if (r_s10_h < H_MIN) begin
                r_s11_h <= HEIGHT_BITS'(H_MIN);
            end else begin
                r_s11_h <= HEIGHT_BITS'(r_s10_h);
            end
        end
    end

    assign o_terrain.valid          = r_vld[LAST];
    assign o_terrain.terrain_class  = r_s11_cls;
    assign o_terrain.terrain_height = r_s11_h;

endmodule

// ===== rtl/vnt_hash.sv =====
module vnt_hash import vnt_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [31:0]          i_x,
    input  logic [31:0]          i_y,
    input  logic [31:0]          i_seed,
    output logic [FRAC_BITS-1:0] o_value
);

    logic [31:0]          r_h0;
    logic [31:0]          r_m1;
    logic [31:0]          r_m2;
    logic [FRAC_BITS-1:0] r_val;
    logic [31:0]          n_h0;
    logic [31:0]          n_m1;
    logic [31:0]          n_m2;
    logic [31:0]          n_fin;

    always_comb begin
        n_h0  = i_seed ^ (i_x * HASH_X) ^ (i_y * HASH_Y);
        n_m1  = (r_h0 ^ (r_h0 >> 16)) * HASH_MUL;
        n_m2  = (r_m1 ^ (r_m1 >> 16)) * HASH_MUL;
        n_fin = r_m2 ^ (r_m2 >> 16);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h0  <= n_h0;
            r_m1  <= n_m1;
            r_m2  <= n_m2;
            r_val <= FRAC_BITS'(n_fin >> (32 - FRAC_BITS));
        end
    end

    assign o_value = r_val;

endmodule

// ===== rtl/vnt_checker.sv =====
module vnt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_class,
    input logic [18:0] i_height
);

    // reset empties the pipeline and opens the input
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!i_out_valid && i_in_ready))
        else $error("pipeline not empty after reset");

    // an empty output stage never blocks the input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with output stage empty");

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_class) && $stable(i_height)))
        else $error("stalled result word changed");

endmodule

bind value_noise_terrain_classifier_top vnt_checker u_vnt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_tile.valid),
    .i_in_ready  (i_tile.ready),
    .i_out_valid (o_terrain.valid),
    .i_out_ready (o_terrain.ready),
    .i_class     (o_terrain.terrain_class),
    .i_height    (o_terrain.terrain_height)
);

// ===== sim/vnt_terrain_checker.sv =====
`timescale 1ns / 1ps

module vnt_terrain_checker import vnt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vnt_in_if           mon_tile,
    vnt_out_if          mon_terrain,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    localparam int FB = DEF_FRAC_BITS;
    localparam longint ONE = longint'(1) << FB;
    localparam longint TENTH = (ONE + 5) / 10;
    localparam longint FIFTH = (2 * ONE + 5) / 10;
    localparam longint TWO_FIFTHS = (4 * ONE + 5) / 10;

    typedef struct packed {
        logic [1:0]  cls;
        logic [18:0] height;
    } t_tile_out;

    logic [31:0]  seed;
    t_map_mode    mode;
    logic [23:0]  inv_scale;
    logic [31:0]  inv_area;
    longint       water, dirt, grass;
    t_tile_out    terrain_q[$];
    int           errors;

    assign o_errors  = errors;
    assign o_pending = terrain_q.size();

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint corner_value(logic [31:0] x, logic [31:0] y,
                                            logic [31:0] sd);
        logic [31:0] h;
        h = sd ^ (x * HASH_X) ^ (y * HASH_Y);
        h = (h ^ (h >> 16)) * HASH_MUL;
        h = (h ^ (h >> 16)) * HASH_MUL;
        h = h ^ (h >> 16);
        return longint'(h >> (32 - FB));
    endfunction

    function automatic longint lerp_fx(longint a, longint b, longint t);
        return a + floor_shr((b - a) * t, FB);
    endfunction

    function automatic longint octave_noise(longint x24, longint y24, logic [31:0] sd);
        longint ix, iy, fx, fy, top, bot;
        logic [31:0] x0, y0;
        ix = x24 >>> 24;
        iy = y24 >>> 24;
        fx = (x24 & 64'hFFFFFF) >> (24 - FB);
        fy = (y24 & 64'hFFFFFF) >> (24 - FB);
        x0 = ix[31:0];
        y0 = iy[31:0];
        top = lerp_fx(corner_value(x0, y0, sd), corner_value(x0 + 1, y0, sd), fx);
        bot = lerp_fx(corner_value(x0, y0 + 1, sd), corner_value(x0 + 1, y0 + 1, sd), fx);
        return lerp_fx(top, bot, fy);
    endfunction

    function automatic longint fdiv(longint v, longint d);
        longint qt;
        qt = v / d;
        if ((v % d) != 0 && v < 0) qt -= 1;
        return qt;
    endfunction

    function automatic longint island_falloff(logic [63:0] d2, logic [31:0] inv);
        logic [63:0] p_lo, p_hi, t;
        p_lo = {32'd0, d2[31:0]} * {32'd0, inv};
        p_hi = (d2 >> 32) * {32'd0, inv};
        if (p_hi >= (64'd1 << (8 + 32 - FB))) return longint'(1) << 40;
        t = (p_hi << FB) + (p_lo >> (32 - FB));
        if (t > (64'd1 << 40)) t = 64'd1 << 40;
        return longint'(t);
    endfunction

    function automatic t_tile_out classify_tile(logic signed [23:0] tq,
                                                logic signed [23:0] tr);
        longint q, r, xq, xr, e, h, c;
        t_tile_out res;
        q = tq;
        r = tr;
        xq = q * longint'(inv_scale);
        xr = r * longint'(inv_scale);
        e = (4 * octave_noise(xq, xr, seed) + 2 * octave_noise(xq * 2, xr * 2, seed)
             + octave_noise(xq * 4, xr * 4, seed) + 3) / 7;
        case (mode)
            MODE_ISLAND:      h = e + TENTH - island_falloff(q * q + r * r, inv_area);
            MODE_ARCHIPELAGO: h = e - FIFTH;
            MODE_CONTINENTS: begin
                c = octave_noise(fdiv(q * 16777216, 500), fdiv(r * 16777216, 500),
                                 seed + 1);
                h = e + floor_shr(c * TWO_FIFTHS, FB) - FIFTH;
            end
            default:          h = e + FIFTH;
        endcase
        if (h < water)      res.cls = CLS_WATER;
        else if (h < dirt)  res.cls = CLS_DIRT;
        else if (h < grass) res.cls = CLS_GRASS;
        else                res.cls = CLS_MOUNTAIN;
        if (h > 262143)  h = 262143;
        if (h < -262144) h = -262144;
        res.height = h[18:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_tile_out want;
        if (!i_rst_n) begin
            seed <= RST_SEED;
            mode <= MODE_ISLAND;
            inv_scale <= RST_INV_SCALE;
            inv_area <= RST_INV_AREA;
            water <= longint'($signed(RST_WATER));
            dirt <= longint'($signed(RST_DIRT));
            grass <= longint'($signed(RST_GRASS));
            terrain_q.delete();
            errors = 0;
        end else begin
            if (mon_tile.valid && mon_tile.ready)
                terrain_q.push_back(classify_tile(mon_tile.tile_q, mon_tile.tile_r));
            if (mon_terrain.valid && mon_terrain.ready) begin
                if (terrain_q.size() == 0) begin
                    report_mismatch("unexpected word", 0, 0);
                end else begin
                    want = terrain_q.pop_front();
                    if (mon_terrain.terrain_class !== want.cls)
                        report_mismatch("class", mon_terrain.terrain_class, want.cls);
                    if (mon_terrain.terrain_height !== want.height)
                        report_mismatch("height", mon_terrain.terrain_height, want.height);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SEED:      seed <= i_cfg_data;
                    CFG_MODE:      mode <= t_map_mode'(i_cfg_data[1:0]);
                    CFG_INV_SCALE: inv_scale <= i_cfg_data[23:0];
                    CFG_INV_AREA:  inv_area <= i_cfg_data;
                    CFG_WATER:     water <= longint'($signed(i_cfg_data[18:0]));
                    CFG_DIRT:      dirt <= longint'($signed(i_cfg_data[18:0]));
                    CFG_GRASS:     grass <= longint'($signed(i_cfg_data[18:0]));
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== sim/tb_value_noise_terrain_classifier_top.sv =====
`timescale 1ns / 1ps

module tb_value_noise_terrain_classifier_top;
    import vnt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    int          errors, pending, cycles;
    int          send_idle_pct, recv_idle_pct;
    bit          hold_recv;

    vnt_in_if #(.COORD_BITS(24)) tile_if ();
    vnt_out_if                   terrain_if ();

    initial begin
        tile_if.valid = 1'b0;
        tile_if.tile_q = '0;
        tile_if.tile_r = '0;
        terrain_if.ready = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    value_noise_terrain_classifier_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_tile(tile_if.sink),
        .o_terrain(terrain_if.source), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data));

    vnt_terrain_checker checker_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .mon_tile(tile_if),
        .mon_terrain(terrain_if), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending));

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_recv) terrain_if.ready <= 1'b0;
        else terrain_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_tile(logic [23:0] q, logic [23:0] r);
        while ($urandom_range(99) < send_idle_pct) begin
            tile_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        tile_if.valid <= 1'b1;
        tile_if.tile_q <= q;
        tile_if.tile_r <= r;
        @(posedge i_clk);
        while (!tile_if.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        tile_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (15) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(3))
            0: return 24'($signed($urandom_range(400)) - 200);
            1: return 24'($signed($urandom_range(8000)) - 4000);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic setup_random();
        write_reg(CFG_SEED, $urandom);
        write_reg(CFG_MODE, $urandom_range(3));
        case ($urandom_range(3))
            0: write_reg(CFG_INV_SCALE, 1);
            1: write_reg(CFG_INV_SCALE, 32'hFFFFFF);
            default: write_reg(CFG_INV_SCALE, $urandom_range(24'hFFFFFF, 1));
        endcase
        write_reg(CFG_INV_AREA, ($urandom_range(1)) ? $urandom : $urandom_range(2000000));
        write_reg(CFG_WATER, $urandom_range(40000));
        write_reg(CFG_DIRT, 40000 + $urandom_range(20000));
        write_reg(CFG_GRASS, ($urandom_range(3) == 0) ? 32'h7FFFF : 60000 + $urandom_range(20000));
    endtask

    initial begin
        logic [23:0] edges[6];
        edges = '{24'h800000, 24'h7FFFFF, 24'h0, 24'hFFFFFF, 24'h1, 24'h000200};
        cycles = 0;
        hold_recv = 0;
        send_idle_pct = 12;
        recv_idle_pct = 68;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: reset settings, then each mode with coordinate extremes
        for (int m = 0; m < 4; m++) begin
            write_reg(CFG_MODE, m);
            for (int k = 0; k < 6; k++) send_tile(edges[k], edges[5 - k]);
            drain();
        end
        write_reg(CFG_WATER, 32'h40000);
        write_reg(CFG_DIRT, 32'h7FFFF);
        write_reg(CFG_GRASS, 32'h3FFFF);
        write_reg(CFG_INV_AREA, 32'hFFFFFFFF);
        write_reg(CFG_MODE, 32'(MODE_ISLAND));
        send_tile(24'h7FFFFF, 24'h800000);
        drain();
        for (int ph = 0; ph < 15; ph++) begin
            if (ph == 5)  begin send_idle_pct = 68; recv_idle_pct = 12; end
            if (ph == 10) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            setup_random();
            if (ph == 3) begin
                fork
                    begin
                        hold_recv = 1;
                        repeat (200) @(posedge i_clk);
                        hold_recv = 0;
                    end
                    for (int n = 0; n < 50; n++) send_tile(rand_coord(), rand_coord());
                join
            end else begin
                for (int n = 0; n < 50; n++) send_tile(rand_coord(), rand_coord());
            end
            drain();
        end
        if (errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule
